// ===== design/hex_word_stream_loader_assert.svh =====
// assertion macros for the hex word stream loader
`ifndef HEX_WORD_STREAM_LOADER_ASSERT_SVH
`define HEX_WORD_STREAM_LOADER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HWSL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hwsl assertion failed");
`define HWSL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hwsl implication failed");
`else
`define HWSL_ASSERT(label, clk, rst, prop)
`define HWSL_ASSERT_IMP(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/hwsl_pkg.sv =====
package hwsl_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_BAD_TERM = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  localparam logic [7:0] LF_CHAR = 8'h0a;

  localparam logic [3:0] PHASE_LINE_START = 4'd0;
  localparam logic [3:0] PHASE_FIRST_DIGIT = 4'd1;
  localparam logic [3:0] PHASE_LAST_DIGIT = 4'd7;
  localparam logic [3:0] PHASE_WAIT_LF = 4'd8;

  localparam logic [31:0] RESET_BASE = 32'h2004_0000;
  localparam logic [15:0] RESET_CAPACITY = 16'hff00;

  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_CAPACITY_WORDS = 1'b1;

  typedef struct packed {
    logic [3:0]  phase;
    logic [31:0] acc;
    logic [15:0] count;
    logic        done;
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] data;
    logic [15:0] word_count;
  } result_t;

endpackage

// ===== design/hwsl_step.sv =====
module hwsl_step (
  input  hwsl_pkg::state_t  state,
  input  logic [7:0]        character,
  input  logic [31:0]       base_address,
  input  logic [15:0]       capacity_words,
  output hwsl_pkg::state_t  state_next,
  output logic              emit,
  output hwsl_pkg::result_t result
);

  function automatic logic [3:0] nybble_of(input logic [7:0] ch);
    logic [3:0] n;
    n = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      n = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      n = ch[3:0] + 4'd9;
    end
    return n;
  endfunction

  logic [31:0] aligned_base;
  logic [31:0] word_address;
  logic [31:0] acc_shift;
  logic [3:0]  nybble;
  logic        is_lf;

  assign aligned_base = {base_address[31:2], 2'b00};
  assign word_address = aligned_base + {14'd0, state.count, 2'b00};
  assign nybble = nybble_of(character);
  assign acc_shift = {state.acc[27:0], nybble};
  assign is_lf = (character == hwsl_pkg::LF_CHAR);

  always_comb begin
    state_next = state;
    emit = 1'b0;
    result.kind = hwsl_pkg::KIND_WRITE;
    result.address = word_address;
    result.data = acc_shift;
    result.word_count = state.count;
    if (state.done) begin
      emit = 1'b0;
    end else if (state.phase == hwsl_pkg::PHASE_WAIT_LF) begin
      state_next.phase = hwsl_pkg::PHASE_LINE_START;
      if (!is_lf) begin
        emit = 1'b1;
        result.kind = hwsl_pkg::KIND_BAD_TERM;
        result.address = aligned_base;
        result.data = {24'd0, character};
        state_next.count = 16'd0;
        state_next.acc = 32'd0;
      end
    end else if (state.phase == hwsl_pkg::PHASE_LINE_START ||
                 state.phase > hwsl_pkg::PHASE_WAIT_LF) begin
      if (is_lf) begin
        emit = 1'b1;
        result.kind = hwsl_pkg::KIND_DONE;
        result.data = state.acc;
        state_next.done = 1'b1;
      end else begin
        state_next.acc = {28'd0, nybble};
        state_next.phase = hwsl_pkg::PHASE_FIRST_DIGIT;
      end
    end else begin
      state_next.acc = acc_shift;
      if (state.phase < hwsl_pkg::PHASE_LAST_DIGIT) begin
        state_next.phase = state.phase + 4'd1;
      end else if (state.count >= capacity_words) begin
        emit = 1'b1;
        result.kind = hwsl_pkg::KIND_OVERFLOW;
        state_next.done = 1'b1;
      end else begin
        emit = 1'b1;
        result.word_count = state.count + 16'd1;
        state_next.count = state.count + 16'd1;
        state_next.phase = hwsl_pkg::PHASE_WAIT_LF;
      end
    end
  end

endmodule

// ===== design/hwsl_result_reg.sv =====
module hwsl_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hwsl_pkg::result_t load_result,
  input  logic              out_ready,
  output logic              out_valid,
  output hwsl_pkg::result_t result
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_result;
    end
  end

endmodule

// ===== design/hex_word_stream_loader.sv =====
// Loads 32-bit words from an ASCII hex stream, one character per word on the input
// channel: eight hex digits per line, most significant first, then a newline. Each
// finished line gives one memory write at aligned base_address + 4 * count; an empty line ends
// the load with a finish report, after which input is swallowed until reset. A wrong
// line terminator reports an error and restarts at the base; a write past
// capacity_words reports overflow and halts. The input register and the result
// register sit on either side of a single decode and update step, so one character is
// taken every cycle but while a result waits downstream in the result register, the
// only throttle on input; each result is registered after its character and the step.
`include "hex_word_stream_loader_assert.svh"

module hex_word_stream_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] address,
  output logic [31:0] data,
  output logic [15:0] word_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic              held;
  logic [7:0]        held_char;
  logic              advance;
  logic              emit;
  logic [31:0]       base_address;
  logic [15:0]       capacity_words;
  hwsl_pkg::state_t  state;
  hwsl_pkg::state_t  state_next;
  hwsl_pkg::result_t step_result;
  hwsl_pkg::result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= hwsl_pkg::RESET_BASE;
      capacity_words <= hwsl_pkg::RESET_CAPACITY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hwsl_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
        hwsl_pkg::CFG_CAPACITY_WORDS: capacity_words <= cfg_data[15:0];
        default: base_address <= base_address;
      endcase
    end
  end

  assign advance = held && (!emit || !out_valid || out_ready);
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  hwsl_step u_step (
    .state          (state),
    .character      (held_char),
    .base_address   (base_address),
    .capacity_words (capacity_words),
    .state_next     (state_next),
    .emit           (emit),
    .result         (step_result)
  );

  hwsl_result_reg u_result_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && emit),
    .load_result (step_result),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .result      (result)
  );

  assign kind = result.kind;
  assign address = result.address;
  assign data = result.data;
  assign word_count = result.word_count;

  `HWSL_ASSERT_IMP(a_done_silent, clk, rst, state.done, !(advance && emit))
  `HWSL_ASSERT(a_phase_range, clk, rst, state.phase <= hwsl_pkg::PHASE_WAIT_LF)
  `HWSL_ASSERT_IMP(a_write_in_capacity, clk, rst, out_valid && kind == hwsl_pkg::KIND_WRITE, word_count <= capacity_words)

endmodule

// ===== verif/hex_word_stream_loader_tb.sv =====
`timescale 1ns / 1ps

module hex_word_stream_loader_tb;

  typedef enum {TAIL_RANDOM, TAIL_BAD, TAIL_GOOD} tail_mode_t;

  localparam int CYCLE_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LINES_PER_PHASE = 8;
  localparam int PHASES = 5;

  class loader_scoreboard;
    logic [31:0]       base;
    logic [15:0]       cap;
    logic [3:0]        phase;
    logic [31:0]       acc;
    logic [15:0]       count;
    bit                halted;
    hwsl_pkg::result_t expected_q[$];
    int                errors;
    int                chars;
    int                seen[4];

    function new();
      base = hwsl_pkg::RESET_BASE;
      cap = hwsl_pkg::RESET_CAPACITY;
      phase = hwsl_pkg::PHASE_LINE_START;
      acc = '0;
      count = '0;
      halted = 0;
      errors = 0;
      chars = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == hwsl_pkg::CFG_BASE_ADDRESS) base = value;
      else cap = value[15:0];
    endfunction

    function logic [3:0] hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c[3:0];
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return c[3:0] + 4'd9;
      return 4'd0;
    endfunction

    function logic [31:0] word_addr();
      return {base[31:2], 2'b00} + {14'd0, count, 2'b00};
    endfunction

    function void expect_result(hwsl_pkg::kind_t k, logic [31:0] a, logic [31:0] d,
                                logic [15:0] n);
      hwsl_pkg::result_t r;
      r.kind = k;
      r.address = a;
      r.data = d;
      r.word_count = n;
      expected_q.push_back(r);
    endfunction

    function void note_char(logic [7:0] c);
      chars++;
      if (halted) return;
      if (phase == hwsl_pkg::PHASE_WAIT_LF) begin
        if (c != hwsl_pkg::LF_CHAR) begin
          expect_result(hwsl_pkg::KIND_BAD_TERM, {base[31:2], 2'b00}, {24'd0, c}, count);
          count = '0;
          acc = '0;
        end
        phase = hwsl_pkg::PHASE_LINE_START;
        return;
      end
      if (phase > hwsl_pkg::PHASE_WAIT_LF) phase = hwsl_pkg::PHASE_LINE_START;
      if (phase == hwsl_pkg::PHASE_LINE_START) begin
        if (c == hwsl_pkg::LF_CHAR) begin
          expect_result(hwsl_pkg::KIND_DONE, word_addr(), acc, count);
          halted = 1;
        end else begin
          acc = {28'd0, hex_value(c)};
          phase = hwsl_pkg::PHASE_FIRST_DIGIT;
        end
        return;
      end
      acc = {acc[27:0], hex_value(c)};
      if (phase < hwsl_pkg::PHASE_LAST_DIGIT) begin
        phase = phase + 4'd1;
        return;
      end
      if (count >= cap) begin
        expect_result(hwsl_pkg::KIND_OVERFLOW, word_addr(), acc, count);
        halted = 1;
        return;
      end
      expect_result(hwsl_pkg::KIND_WRITE, word_addr(), acc, count + 16'd1);
      count = count + 16'd1;
      phase = hwsl_pkg::PHASE_WAIT_LF;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(hwsl_pkg::kind_t k, logic [31:0] a, logic [31:0] d, logic [15:0] n);
      hwsl_pkg::result_t w;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d addr %h", k, a));
        return;
      end
      w = expected_q.pop_front();
      seen[w.kind]++;
      if (k !== w.kind)
        report_mismatch($sformatf("kind %0d, want %0d", k, w.kind));
      if (a !== w.address)
        report_mismatch($sformatf("address %h, want %h", a, w.address));
      if (d !== w.data)
        report_mismatch($sformatf("data %h, want %h", d, w.data));
      if (n !== w.word_count)
        report_mismatch($sformatf("word_count %0d, want %0d", n, w.word_count));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  character;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [31:0] data;
  logic [15:0] word_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  loader_scoreboard sb;
  bit    calm = 0;
  int    hold_cycles = 0;
  int    cycles = 0;
  string hex_digits = "0123456789abcdefABCDEF";
  logic [7:0] opening_chars [18] = '{8'h00, "9", "a", "f", "A", "F", "g", 8'hff,
                                     hwsl_pkg::LF_CHAR,
                                     "f", "F", "f", "F", "f", "F", "f", "F", 8'h00};

  hex_word_stream_loader i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .character  (character),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .address    (address),
    .data       (data),
    .word_count (word_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hex_word_stream_loader regression: fail");
      $finish;
    end
  end

  // downstream stalls
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
    else if (!calm && $urandom_range(4) == 0) hold_cycles = $urandom_range(3, 1);
    out_ready <= (hold_cycles == 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(hwsl_pkg::kind_t'(kind), address, data, word_count);
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = (!calm && $urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    character <= c;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    sb.note_char(c);
  endtask

  task automatic send_line(input tail_mode_t mode);
    logic [7:0] c;
    bit good_tail;
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(4) == 0) begin
        c = 8'($urandom_range(255));
        if (k == 0 && c == hwsl_pkg::LF_CHAR) c = "g";
      end else begin
        c = hex_digits[$urandom_range(21)];
      end
      send_char(c);
    end
    case (mode)
      TAIL_GOOD: good_tail = 1;
      TAIL_BAD: good_tail = 0;
      default: good_tail = (sb.count < sb.cap) && ($urandom_range(7) != 0);
    endcase
    if (good_tail) begin
      send_char(hwsl_pkg::LF_CHAR);
    end else begin
      c = 8'($urandom_range(255));
      if (c == hwsl_pkg::LF_CHAR) c = 8'hff;
      send_char(c);
    end
  endtask

  task automatic write_regs(input logic [31:0] base_value, input logic [15:0] cap_value);
    cfg_valid <= 1'b1;
    cfg_index <= hwsl_pkg::CFG_BASE_ADDRESS;
    cfg_data <= base_value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    sb.write_reg(hwsl_pkg::CFG_BASE_ADDRESS, base_value);
    cfg_index <= hwsl_pkg::CFG_CAPACITY_WORDS;
    cfg_data <= {16'd0, cap_value};
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    sb.write_reg(hwsl_pkg::CFG_CAPACITY_WORDS, {16'd0, cap_value});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] phase_base [PHASES];
    logic [15:0] phase_cap [PHASES];
    bit end_by_overflow;

    rst = 1'b1;
    in_valid = 1'b0;
    character = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = hwsl_pkg::CFG_BASE_ADDRESS;
    cfg_data = '0;
    sb = new();

    phase_base[0] = 32'h0000_0000;
    phase_cap[0] = 16'd1;
    phase_base[1] = 32'hffff_ffff;
    phase_cap[1] = 16'hffff;
    phase_base[2] = $urandom;
    phase_cap[2] = 16'($urandom_range(6, 2));
    phase_base[3] = 32'hffff_fff0;
    phase_cap[3] = 16'($urandom_range(65535, 1));
    phase_base[4] = $urandom;
    phase_cap[4] = 16'hffff;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_chars[i]) send_char(opening_chars[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_regs(phase_base[p], phase_cap[p]);
      for (int n = 0; n < LINES_PER_PHASE; n++) send_line(TAIL_RANDOM);
      // leave the count cleared before the next register change
      send_line(TAIL_BAD);
      drain();
    end

    calm = 1;
    end_by_overflow = 1'($urandom_range(1));
    if (end_by_overflow) begin
      write_regs($urandom, 16'($urandom_range(3, 1)));
      while (!sb.halted) send_line(TAIL_GOOD);
    end else begin
      send_char(hwsl_pkg::LF_CHAR);
    end
    // halted: everything from here on must be swallowed
    for (int n = 0; n < 12; n++)
      send_char(n[0] ? hwsl_pkg::LF_CHAR : 8'($urandom_range(255)));
    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("run covered %0d characters over %0d base/capacity settings, ended by %s",
             sb.chars, end_by_overflow ? PHASES + 2 : PHASES + 1,
             end_by_overflow ? "overflow" : "empty line");
    $display("results: %0d writes, %0d bad terminators, %0d finish, %0d overflow",
             sb.seen[hwsl_pkg::KIND_WRITE], sb.seen[hwsl_pkg::KIND_BAD_TERM],
             sb.seen[hwsl_pkg::KIND_DONE], sb.seen[hwsl_pkg::KIND_OVERFLOW]);
    if (sb.errors == 0) begin
      $display("hex_word_stream_loader regression: pass");
    end else begin
      $display("hex_word_stream_loader regression: fail");
    end
    $finish;
  end

endmodule

// ===== hex_word_stream_loader.f =====
+incdir+design
design/hwsl_pkg.sv
design/hwsl_step.sv
design/hwsl_result_reg.sv
design/hex_word_stream_loader.sv
verif/hex_word_stream_loader_tb.sv
